@@ design/sspq_pkg.sv @@
// Shared types, sizes and codes of the stable sorted priority queue.
// Depends on nothing; sspq_seq, the core and the testbench import it.
`default_nettype none

package sspq_pkg;

    // Queue size and the widths that follow from it.
    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of one entry.
    localparam int PRIO_W   = 16;
    localparam int TAG_W    = 16;
    localparam int ENTRY_W  = PRIO_W + TAG_W;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Operation codes of the request channel.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Status codes of the response channel.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // One finished result, handed from the sequencer to the output stage.
    typedef struct packed {
        logic                popped_valid;
        logic [PRIO_W-1:0]   prio;
        logic [TAG_W-1:0]    tag;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    count;
    } result_t;

endpackage

`default_nettype wire

@@ design/sspq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module sspq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/sspq_seq.sv @@
// Sequencer of the queue: entry memory, one shared priority comparator and
// the state machine that scans and shifts entries one per cycle.
// Depends on sspq_pkg and sspq_ram.
`default_nettype none

module sspq_seq
    import sspq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    output logic                          req_stall,
    input  wire logic                     kind,
    input  wire logic signed [PRIO_W-1:0] new_priority,
    input  wire logic        [TAG_W-1:0]  new_tag,
    input  wire logic                     slot_free,
    output logic                          res_load,
    output result_t                       res
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_PUSH_SCAN = 3'd1;
    localparam logic [2:0] S_PUSH_HEAD = 3'd2;
    localparam logic [2:0] S_POP_HEAD  = 3'd3;
    localparam logic [2:0] S_POP_SHIFT = 3'd4;
    localparam logic [2:0] S_DONE      = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg,   idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PRIO_W-1:0] prio_reg,  prio_next;
    logic [TAG_W-1:0]  tag_reg,   tag_next;
    result_t           res_reg,   res_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    logic [PRIO_W-1:0]  rd_prio;
    logic [TAG_W-1:0]   rd_tag;
    logic               rd_later;
    logic [CNT_W-1:0]   count_m1;
    logic [CNT_W-1:0]   count_p1;
    logic [ADDR_W-1:0]  last_idx;

    sspq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_prio = mem_rdata[ENTRY_W-1:TAG_W];
    assign rd_tag  = mem_rdata[TAG_W-1:0];

    // Shared comparator: the stored entry leaves after the new one only if
    // its priority is strictly greater, which keeps equal priorities stable.
    assign rd_later = $signed(rd_prio) > $signed(prio_reg);

    assign count_m1 = count_reg - 1'b1;
    assign count_p1 = count_reg + 1'b1;
    assign last_idx = count_m1[ADDR_W-1:0];

    // Next-state and datapath control.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        prio_next  = prio_reg;
        tag_next   = tag_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = {prio_reg, tag_reg};
        mem_raddr  = idx_reg;
        res_load   = 1'b0;
        req_stall  = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    prio_next = new_priority;
                    tag_next  = new_tag;
                    res_next  = '{popped_valid: 1'b0, prio: '0, tag: '0,
                                  status: ST_OK, count: count_reg};
                    if (kind == KIND_PUSH)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            res_next.status = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = S_PUSH_HEAD;
                        end
                        else
                        begin
                            mem_raddr  = last_idx;
                            idx_next   = last_idx;
                            state_next = S_PUSH_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            mem_raddr  = '0;
                            idx_next   = '0;
                            state_next = S_POP_HEAD;
                        end
                    end
                end
            end

            // Walk down from the tail, moving each later entry up one slot.
            S_PUSH_SCAN:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg + 1'b1;
                if (rd_later)
                begin
                    mem_wdata = mem_rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = S_PUSH_HEAD;
                    end
                    else
                    begin
                        idx_next  = idx_reg - 1'b1;
                        mem_raddr = idx_reg - 1'b1;
                    end
                end
                else
                begin
                    count_next     = count_p1;
                    res_next.count = count_p1;
                    state_next     = S_DONE;
                end
            end

            // The new entry goes to the head slot.
            S_PUSH_HEAD:
            begin
                mem_we         = 1'b1;
                mem_waddr      = '0;
                count_next     = count_p1;
                res_next.count = count_p1;
                state_next     = S_DONE;
            end

            // Capture the head entry, then start shifting the rest down.
            S_POP_HEAD:
            begin
                res_next.popped_valid = 1'b1;
                res_next.prio         = rd_prio;
                res_next.tag          = rd_tag;
                res_next.count        = count_m1;
                count_next            = count_m1;
                if (count_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = ADDR_W'(1);
                    mem_raddr  = ADDR_W'(1);
                    state_next = S_POP_SHIFT;
                end
            end

            // Move entry idx to idx-1; count already holds the old last index.
            S_POP_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg - 1'b1;
                mem_wdata = mem_rdata;
                if (CNT_W'(idx_reg) == count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next  = idx_reg + 1'b1;
                    mem_raddr = idx_reg + 1'b1;
                end
            end

            // Hand the result over once the output register can take it.
            S_DONE:
            begin
                if (slot_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers of the current operation.
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

@@ design/stable_sorted_priority_queue_core.sv @@
// Stable min-first sorted priority queue of CAPACITY entries.
//
// Request channel (req_valid / req_stall): kind selects push or pop; a push
// carries new_priority (signed) and new_tag. A transfer happens on a rising
// edge with req_valid high and req_stall low.
// Response channel (rsp_valid / rsp_stall): one response per request with
// popped_valid, popped_priority, popped_tag, status and occupancy.
//
// One request is worked on at a time; the entry memory has one read and one
// write port and a single comparator, so one entry is visited per cycle.
// A push walks from the tail down to its landing position and a pop shifts
// every remaining entry down; an error response skips the entry memory. A
// new request is taken only once the previous result has been handed to the
// output register.
//
// Reset empties the queue at once; entry contents are not cleared and are
// never read before they are written. A stalled response stays in the output
// register while the next request is already taken and processed; that
// request then waits for the register before it is handed over.
`default_nettype none

module stable_sorted_priority_queue_core
    import sspq_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire logic                       kind,
    input  wire logic signed [PRIO_W-1:0]   new_priority,
    input  wire logic        [TAG_W-1:0]    new_tag,
    output logic                            rsp_valid,
    input  wire logic                       rsp_stall,
    output logic                            popped_valid,
    output logic signed [PRIO_W-1:0]        popped_priority,
    output logic        [TAG_W-1:0]         popped_tag,
    output logic        [STATUS_W-1:0]      status,
    output logic        [OCC_W-1:0]         occupancy
);

    logic                   slot_free;
    logic                   res_load;
    result_t                res;
    logic                   rsp_valid_reg;
    result_t                out_reg;
    logic [CNT_W+OCC_W-1:0] count_ext;

    sspq_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .new_priority (new_priority),
        .new_tag      (new_tag),
        .slot_free    (slot_free),
        .res_load     (res_load),
        .res          (res)
    );

    // The output register is free when empty or when its transfer completes.
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    // Response fields.
    assign count_ext       = (CNT_W + OCC_W)'(out_reg.count);
    assign rsp_valid       = rsp_valid_reg;
    assign popped_valid    = out_reg.popped_valid;
    assign popped_priority = $signed(out_reg.prio);
    assign popped_tag      = out_reg.tag;
    assign status          = out_reg.status;
    assign occupancy       = count_ext[OCC_W-1:0];

    // A returned entry always comes with an ok status.
    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && out_reg.popped_valid |-> out_reg.status == ST_OK)
        else $error("popped entry with error status");

    // A dropped push is reported only when the queue is full.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && out_reg.status == ST_FULL
        |-> out_reg.count == CNT_W'(CAPACITY))
        else $error("full status with queue not full");

    // The sequencer hands over a result only into a free output register.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> slot_free)
        else $error("result loaded over a pending response");

    // After a request transfer the block stalls requests in the following cycle.
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous one in work");

endmodule

`default_nettype wire

@@ verif/stable_sorted_priority_queue_core_test.sv @@
// Self-checking testbench for the stable sorted priority queue core.
// Pushes and pops are checked against a sorted-array model of the queue kept here.
// Depends on sspq_pkg and stable_sorted_priority_queue_core.
`timescale 1ns / 1ps

module stable_sorted_priority_queue_core_test;
    import sspq_pkg::*;

    // One response as seen on the output channel.
    typedef struct packed {
        logic                       popped_valid;
        logic signed [PRIO_W-1:0]   prio;
        logic        [TAG_W-1:0]    tag;
        logic        [STATUS_W-1:0] status;
        logic        [OCC_W-1:0]    occ;
    } reply_t;

    // One request of the stimulus list, with an optional hand-typed response.
    typedef struct {
        logic                     op;
        logic signed [PRIO_W-1:0] prio;
        logic        [TAG_W-1:0]  tag;
        bit                       typed;
        reply_t                   want;
        bit                       drain_first;
    } queue_req_t;

    localparam int RANDOM_OPS = 1825;

    logic                       clk;
    logic                       rst_n;
    logic                       req_valid;
    logic                       req_stall;
    logic                       kind;
    logic signed [PRIO_W-1:0]   new_priority;
    logic        [TAG_W-1:0]    new_tag;
    logic                       rsp_valid;
    logic                       rsp_stall;
    logic                       popped_valid;
    logic signed [PRIO_W-1:0]   popped_priority;
    logic        [TAG_W-1:0]    popped_tag;
    logic        [STATUS_W-1:0] status;
    logic        [OCC_W-1:0]    occupancy;

    // Model of the queue contents, kept sorted by ascending priority.
    logic signed [PRIO_W-1:0] held_prio [CAPACITY];
    logic        [TAG_W-1:0]  held_tag  [CAPACITY];
    int                       held_count = 0;

    queue_req_t request_list [$];
    reply_t     reply_fifo   [$];
    int         mismatch_count = 0;

    stable_sorted_priority_queue_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .kind            (kind),
        .new_priority    (new_priority),
        .new_tag         (new_tag),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .popped_valid    (popped_valid),
        .popped_priority (popped_priority),
        .popped_tag      (popped_tag),
        .status          (status),
        .occupancy       (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Applies one push or pop to the queue model and returns its response.
    // A push goes behind every held entry of equal or lower priority.
    function automatic reply_t apply_queue_op(input logic op,
                                              input logic signed [PRIO_W-1:0] p,
                                              input logic [TAG_W-1:0] t);
        reply_t r;
        int     pos;
        int     i;
        r = '0;
        if (op == KIND_PUSH)
        begin
            if (held_count >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                pos = 0;
                while (pos < held_count && held_prio[pos] <= p)
                    pos++;
                for (i = held_count; i > pos; i--)
                begin
                    held_prio[i] = held_prio[i - 1];
                    held_tag[i]  = held_tag[i - 1];
                end
                held_prio[pos] = p;
                held_tag[pos]  = t;
                held_count++;
            end
        end
        else
        begin
            if (held_count == 0)
                r.status = ST_EMPTY;
            else
            begin
                r.popped_valid = 1'b1;
                r.prio         = held_prio[0];
                r.tag          = held_tag[0];
                for (i = 1; i < held_count; i++)
                begin
                    held_prio[i - 1] = held_prio[i];
                    held_tag[i - 1]  = held_tag[i];
                end
                held_count--;
            end
        end
        r.occ = OCC_W'(held_count);
        return r;
    endfunction

    function automatic reply_t mk_reply(input logic v, input logic signed [PRIO_W-1:0] p,
                                        input logic [TAG_W-1:0] t,
                                        input logic [STATUS_W-1:0] s,
                                        input logic [OCC_W-1:0] o);
        reply_t r;
        r.popped_valid = v;
        r.prio         = p;
        r.tag          = t;
        r.status       = s;
        r.occ          = o;
        return r;
    endfunction

    function automatic void add_op(input logic op, input logic signed [PRIO_W-1:0] p,
                                   input logic [TAG_W-1:0] t, input bit typed,
                                   input reply_t want, input bit drain);
        queue_req_t q;
        q.op          = op;
        q.prio        = p;
        q.tag         = t;
        q.typed       = typed;
        q.want        = want;
        q.drain_first = drain;
        request_list.push_back(q);
    endfunction

    // Wait length for one transfer: drawn at random, with calm stretches of none.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    // Builds the directed table and the random requests that follow it.
    function automatic void build_requests();
        int                       n;
        int                       seg_left;
        int                       push_pct;
        logic                     op;
        logic signed [PRIO_W-1:0] p;
        seg_left = 0;
        push_pct = 50;

        // Pop on an empty queue right after reset, then both priority extremes.
        add_op(KIND_POP, 0, 0, 1, mk_reply(0, 0, 0, ST_EMPTY, 0), 0);
        add_op(KIND_PUSH, 16'sh7fff, 16'hffff, 1, mk_reply(0, 0, 0, ST_OK, 1), 0);
        add_op(KIND_PUSH, 16'sh8000, 16'h0000, 1, mk_reply(0, 0, 0, ST_OK, 2), 0);
        // Two equal priorities must leave in arrival order.
        add_op(KIND_PUSH, 0, 16'h1234, 0, '0, 0);
        add_op(KIND_PUSH, 0, 16'h5678, 0, '0, 0);
        add_op(KIND_PUSH, -16'sd1, 16'haaaa, 0, '0, 0);
        add_op(KIND_POP, 0, 0, 1, mk_reply(1, 16'sh8000, 16'h0000, ST_OK, 4), 0);
        add_op(KIND_POP, 0, 0, 0, '0, 0);
        add_op(KIND_POP, 0, 0, 0, '0, 0);
        // Fill to capacity with extreme priorities, then push once more on full.
        for (n = 0; n < CAPACITY - 2; n++)
            add_op(KIND_PUSH, (n % 2) ? 16'sh7fff : 16'sh8000, TAG_W'(16'h0100 + n), 0, '0, 0);
        add_op(KIND_PUSH, 16'sh1111, 16'h5555, 1,
               mk_reply(0, 0, 0, ST_FULL, OCC_W'(CAPACITY)), 0);
        add_op(KIND_POP, 0, 0, 0, '0, 0);

        // Random part: segments lean to pushes or pops so the queue swings
        // between empty and full; small priorities make ties common.
        for (n = 0; n < RANDOM_OPS; n++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(30, 80);
                case ($urandom_range(0, 2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            seg_left--;
            op = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
            case ($urandom_range(0, 7))
                0:       p = 16'sh8000;
                1:       p = 16'sh7fff;
                2:       p = -16'sd1;
                3, 4, 5: p = 16'($urandom_range(0, 7) - 4);
                default: p = 16'($urandom);
            endcase
            add_op(op, p, 16'($urandom), 0, '0, (n % 300) == 150);
        end
    endfunction

    // Request side: walks the list, idles at random and predicts each transfer.
    initial
    begin
        queue_req_t item;
        reply_t     predicted;
        int         gap;
        int         send_calm;
        int         idx;
        send_calm    = 0;
        rst_n        <= 1'b0;
        req_valid    <= 1'b0;
        kind         <= KIND_PUSH;
        new_priority <= '0;
        new_tag      <= '0;
        build_requests();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (idx = 0; idx < request_list.size(); idx++)
        begin
            item = request_list[idx];
            gap  = draw_wait(send_calm);
            if (item.drain_first && gap == 0)
                gap = 1;
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                // Hold off until every outstanding response has come back.
                if (item.drain_first)
                    while (reply_fifo.size() != 0)
                        @(posedge clk);
            end
            req_valid    <= 1'b1;
            kind         <= item.op;
            new_priority <= item.prio;
            new_tag      <= item.tag;
            @(posedge clk);
            while (req_stall)
                @(posedge clk);
            predicted = apply_queue_op(item.op, item.prio, item.tag);
            reply_fifo.push_back(item.typed ? item.want : predicted);
        end
        req_valid <= 1'b0;

        // Let the last responses drain, then keep watching for stray responses.
        while (reply_fifo.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Response side: checks each transfer and stalls at random.
    initial
    begin
        reply_t seen;
        reply_t want;
        int     stall_left;
        int     recv_calm;
        stall_left = 0;
        recv_calm  = 0;
        rsp_stall  <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                seen = mk_reply(popped_valid, popped_priority, popped_tag, status, occupancy);
                if (reply_fifo.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: unexpected response valid=%0b prio=%0d tag=%h st=%0d occ=%0d",
                                 seen.popped_valid, seen.prio, seen.tag, seen.status, seen.occ);
                end
                else
                begin
                    want = reply_fifo.pop_front();
                    if (seen.popped_valid !== want.popped_valid || seen.prio !== want.prio ||
                        seen.tag !== want.tag || seen.status !== want.status ||
                        seen.occ !== want.occ)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("ERROR: at %0t expected valid=%0b prio=%0d tag=%h st=%0d occ=%0d",
                                     $realtime, want.popped_valid, want.prio, want.tag,
                                     want.status, want.occ);
                            $display("       got      valid=%0b prio=%0d tag=%h st=%0d occ=%0d",
                                     seen.popped_valid, seen.prio, seen.tag,
                                     seen.status, seen.occ);
                        end
                    end
                end
                stall_left = draw_wait(recv_calm);
                rsp_stall <= (stall_left > 0);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= (stall_left > 0);
            end
        end
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
